FILE: rtl/core/mwr_pkg.sv
// ----------------------------------------------------------------------------
// Marker warp resampler package
// Shared types, codes and the mix rounding and saturation function.
// ----------------------------------------------------------------------------
package mwr_pkg;

    // Input item actions (carried on s_tuser)
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_MAP  = 2'd1;
    localparam logic [1:0] ACT_MIX  = 2'd2;

    // Result kinds (carried on m_tuser)
    localparam logic [1:0] KIND_MAPPED  = 2'd0;
    localparam logic [1:0] KIND_MIXED   = 2'd1;
    localparam logic [1:0] KIND_UNAVAIL = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SPB   = 2'd0;
    localparam logic [1:0] CFG_COUNT = 2'd1;
    localparam logic [1:0] CFG_GAIN  = 2'd2;

    // Shift unit operations
    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    localparam int STEP_W = 7;
    localparam int ACC_W  = 88;
    localparam int MLT_W  = 48;
    localparam int REM_W  = 40;

    // Iteration counts of the shift unit for each job
    localparam logic [STEP_W-1:0] STEPS_BEAT = 7'd40;
    localparam logic [STEP_W-1:0] STEPS_PROD = 7'd40;
    localparam logic [STEP_W-1:0] STEPS_SEG  = 7'd48;
    localparam logic [STEP_W-1:0] STEPS_FRAC = 7'd16;
    localparam logic [STEP_W-1:0] STEPS_GAIN = 7'd18;

    typedef struct packed {
        logic              start;
        logic              op;
        logic [STEP_W-1:0] steps;
    } mwr_ctrl_t;

    // Round the Q.32 gained sample half up, add the mix value, saturate to 24 bits
    function automatic logic [23:0] mix_finish(input logic signed [59:0] g,
                                               input logic signed [23:0] mix);
        logic signed [59:0] t;
        logic signed [27:0] u;
        logic signed [28:0] s;
        logic [23:0]        r;
        t = g + 60'sh0_0000_0080_0000_00;
        u = t[59:32];
        s = {u[27], u} + {{5{mix[23]}}, mix};
        if (s > 29'sd8388607) begin
            r = 24'h7F_FFFF;
        end else if (s < -29'sd8388608) begin
            r = 24'h80_0000;
        end else begin
            r = s[23:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/mwr_shift_unit.sv
// ----------------------------------------------------------------------------
// Marker warp resampler shift unit
// Shared shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module mwr_shift_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mwr_pkg::mwr_ctrl_t                ctrl,
    input  logic [mwr_pkg::ACC_W-1:0]         opnd_a,   // multiplicand or divisor
    input  logic [mwr_pkg::MLT_W-1:0]         opnd_b,   // multiplier or dividend low bits
    input  logic [mwr_pkg::REM_W-1:0]         opnd_c,   // initial remainder
    output logic                              done,
    output logic [mwr_pkg::ACC_W-1:0]         result
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic                          op_reg, op_next;
    logic [mwr_pkg::STEP_W-1:0]    cnt_reg, cnt_next;
    logic [mwr_pkg::ACC_W-1:0]     a_reg, a_next;
    logic [mwr_pkg::MLT_W-1:0]     b_reg, b_next;
    logic [mwr_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic [mwr_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [mwr_pkg::MLT_W-1:0]     q_reg, q_next;

    logic [mwr_pkg::REM_W:0]       r2;
    logic [mwr_pkg::REM_W:0]       dvs;
    logic [mwr_pkg::REM_W:0]       diff;
    logic                          ge;

    assign r2   = {rem_reg, b_reg[mwr_pkg::MLT_W-1]};
    assign dvs  = {1'b0, a_reg[mwr_pkg::REM_W-1:0]};
    assign diff = r2 - dvs;
    assign ge   = (r2 >= dvs);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            op_next   = ctrl.op;
            cnt_next  = ctrl.steps;
            a_next    = opnd_a;
            b_next    = opnd_b;
            acc_next  = '0;
            rem_next  = opnd_c;
            q_next    = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == mwr_pkg::STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            if (op_reg == mwr_pkg::OP_MUL) begin
                // add the shifted multiplicand where the multiplier bit is set
                if (b_reg[0]) begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = {a_reg[mwr_pkg::ACC_W-2:0], 1'b0};
                b_next = {1'b0, b_reg[mwr_pkg::MLT_W-1:1]};
            end else begin
                // one restoring division step, quotient bit in from the right
                rem_next = ge ? diff[mwr_pkg::REM_W-1:0] : r2[mwr_pkg::REM_W-1:0];
                q_next   = {q_reg[mwr_pkg::MLT_W-2:0], ge};
                b_next   = {b_reg[mwr_pkg::MLT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done   = done_reg;
    assign result = (op_reg == mwr_pkg::OP_MUL) ? acc_reg
                                                : {{(mwr_pkg::ACC_W-mwr_pkg::MLT_W){1'b0}}, q_reg};

endmodule

FILE: rtl/core/marker_warp_resampler_core.sv
// ----------------------------------------------------------------------------
// Marker warp resampler core
// Varispeed resampler: warp marker table, position mapping and stereo mix.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one word per item; s_tuser gives the action (load marker,
//   map position, mix). Load words write the marker table and give no result.
//   Map words give one m_ word with the source index and fraction, or the
//   'unavailable' kind; mix words give one m_ word with the two mixed samples.
//   Configuration (samples per beat, marker count, gain) is for the user to write
//   on cfg_ only while idle, not enforced by the block; cfg_ready is always high.
// Sequencing:
//   A map word scans the markers and uses the shared shift unit (beat division,
//   segment product, segment division, one bit per cycle). A mix word runs four
//   serial multiplies in the same unit. s_tready is high only while the
//   sequencer is idle.
// Reset and stall:
//   aresetn clears the sequencer, output valid, spb and count, and sets gain to
//   65536; the marker table holds no reset value. A finished result waits in
//   the output register while the next item is accepted; a stalled receiver
//   holds the next result in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module marker_warp_resampler_core #(
    parameter int MAX_MARKERS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // marker_slot, marker_beat, marker_source, out_pos, left_a, left_b,
    // right_a, right_b, mix_in_left, mix_in_right, zero pad
    input  logic [279:0] s_tdata,
    // action
    input  logic [1:0]   s_tuser,
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    // source_index, source_fraction, mix_left, mix_right
    output logic [95:0]  m_tdata,
    // result_kind
    output logic [1:0]   m_tuser,
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [35:0]  cfg_data
);

    localparam int AW = $clog2(MAX_MARKERS);
    localparam int NW = $clog2(MAX_MARKERS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_BDIV = 4'd1;
    localparam logic [3:0] S_HI   = 4'd2;
    localparam logic [3:0] S_LO   = 4'd3;
    localparam logic [3:0] S_SCAN = 4'd4;
    localparam logic [3:0] S_PMUL = 4'd5;
    localparam logic [3:0] S_SDIV = 4'd6;
    localparam logic [3:0] S_M1L  = 4'd7;
    localparam logic [3:0] S_M2L  = 4'd8;
    localparam logic [3:0] S_M1R  = 4'd9;
    localparam logic [3:0] S_M2R  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    // Input fields
    logic [1:0]  in_action;
    logic [3:0]  in_slot;
    logic [39:0] in_beat;
    logic [47:0] in_source;
    logic [39:0] in_pos;
    logic [23:0] in_la, in_lb, in_ra, in_rb, in_mil, in_mir;

    assign in_action = s_tuser;
    assign in_slot   = s_tdata[3:0];
    assign in_beat   = s_tdata[43:4];
    assign in_source = s_tdata[91:44];
    assign in_pos    = s_tdata[131:92];
    assign in_la     = s_tdata[155:132];
    assign in_lb     = s_tdata[179:156];
    assign in_ra     = s_tdata[203:180];
    assign in_rb     = s_tdata[227:204];
    assign in_mil    = s_tdata[251:228];
    assign in_mir    = s_tdata[275:252];

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    // Configuration registers
    logic [35:0] spb_reg;
    logic [4:0]  count_reg;
    logic [17:0] gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spb_reg   <= '0;
            count_reg <= '0;
            gain_reg  <= 18'd65536;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mwr_pkg::CFG_SPB:   spb_reg   <= cfg_data;
                mwr_pkg::CFG_COUNT: count_reg <= cfg_data[4:0];
                mwr_pkg::CFG_GAIN:  gain_reg  <= cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // Effective marker count, clamped to the table depth
    logic [31:0]   cnt32;
    logic [NW-1:0] n_eff;
    logic [AW-1:0] last_addr;
    logic          map_avail;
    logic          beat_sat;

    assign cnt32     = 32'(count_reg);
    assign n_eff     = (cnt32 > 32'(MAX_MARKERS)) ? NW'(MAX_MARKERS) : NW'(cnt32);
    assign last_addr = AW'(n_eff - NW'(1));
    assign map_avail = (n_eff >= NW'(2)) && (spb_reg != '0);
    // quotient beyond 40 bits: pos * 2^32 >= spb * 2^40
    assign beat_sat  = ({4'b0, in_pos} >= {spb_reg, 8'b0});

    // Marker table: one write port for loads, one registered read port
    logic [39:0]   beat_mem [MAX_MARKERS];
    logic [47:0]   src_mem  [MAX_MARKERS];
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          load_we;
    logic [39:0]   rd_beat_reg;
    logic [47:0]   rd_src_reg;

    assign wr_addr = AW'(in_slot);
    assign load_we = s_acc && (in_action == mwr_pkg::ACT_LOAD)
                     && (32'(in_slot) < 32'(MAX_MARKERS));

    always_ff @(posedge aclk) begin
        if (load_we) begin
            beat_mem[wr_addr] <= in_beat;
            src_mem[wr_addr]  <= in_source;
        end
        rd_beat_reg <= beat_mem[rd_addr];
        rd_src_reg  <= src_mem[rd_addr];
    end

    // Shared shift unit
    mwr_pkg::mwr_ctrl_t        u_ctrl_reg, u_ctrl_next;
    logic [mwr_pkg::ACC_W-1:0] u_a_reg, u_a_next;
    logic [mwr_pkg::MLT_W-1:0] u_b_reg, u_b_next;
    logic [mwr_pkg::REM_W-1:0] u_c_reg, u_c_next;
    logic                      u_done;
    logic [mwr_pkg::ACC_W-1:0] u_res;

    mwr_shift_unit u_shift (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (u_ctrl_reg),
        .opnd_a  (u_a_reg),
        .opnd_b  (u_b_reg),
        .opnd_c  (u_c_reg),
        .done    (u_done),
        .result  (u_res)
    );

    // Sequencer state and working registers
    logic [3:0]    state_reg, state_next;
    logic [39:0]   beat_reg, beat_next;
    logic [AW-1:0] j_reg, j_next;
    logic          hi_reg, hi_next;
    logic [47:0]   last_src_reg, last_src_next;
    logic [39:0]   prev_beat_reg, prev_beat_next;
    logic [47:0]   prev_src_reg, prev_src_next;
    logic [39:0]   span_reg, span_next;
    logic          neg_reg, neg_next;
    logic [15:0]   held_frac_reg, held_frac_next;
    logic [23:0]   la_reg, la_next, lb_reg, lb_next;
    logic [23:0]   ra_reg, ra_next, rb_reg, rb_next;
    logic [23:0]   mil_reg, mil_next, mir_reg, mir_next;

    // Pending result
    logic [1:0]    res_kind_reg, res_kind_next;
    logic [31:0]   res_index_reg, res_index_next;
    logic [15:0]   res_frac_reg, res_frac_next;
    logic [23:0]   res_ml_reg, res_ml_next;
    logic [23:0]   res_mr_reg, res_mr_next;

    // Output register
    logic          m_valid_reg, m_valid_next;
    logic [1:0]    out_kind_reg, out_kind_next;
    logic [31:0]   out_index_reg, out_index_next;
    logic [15:0]   out_frac_reg, out_frac_next;
    logic [23:0]   out_ml_reg, out_ml_next;
    logic [23:0]   out_mr_reg, out_mr_next;

    // Combinational helpers
    logic          fin_map;
    logic [47:0]   fin_src;
    logic          out_load;
    logic [39:0]   seg_span;
    logic [39:0]   seg_d;
    logic [47:0]   seg_mag;
    logic [24:0]   diff_l, diff_r;
    logic [41:0]   v_mix;
    logic [47:0]   q48;

    assign seg_span = rd_beat_reg - prev_beat_reg;
    assign seg_mag  = (rd_src_reg >= prev_src_reg) ? (rd_src_reg - prev_src_reg)
                                                   : (prev_src_reg - rd_src_reg);
    assign q48      = u_res[47:0];
    assign diff_l   = {in_lb[23], in_lb} - {in_la[23], in_la};
    assign diff_r   = {rb_reg[23], rb_reg} - {ra_reg[23], ra_reg};
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_tready);

    always_comb begin
        // offset into the segment, clamped to [0, span]
        if (beat_reg > prev_beat_reg) begin
            seg_d = beat_reg - prev_beat_reg;
        end else begin
            seg_d = '0;
        end
        if (seg_d > seg_span) begin
            seg_d = seg_span;
        end
    end

    // a * 2^16 plus the fraction product, for whichever channel is in flight
    always_comb begin
        if (state_reg == S_M1L) begin
            v_mix = {{2{la_reg[23]}}, la_reg, 16'b0} + u_res[41:0];
        end else begin
            v_mix = {{2{ra_reg[23]}}, ra_reg, 16'b0} + u_res[41:0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        beat_next      = beat_reg;
        j_next         = j_reg;
        hi_next        = hi_reg;
        last_src_next  = last_src_reg;
        prev_beat_next = prev_beat_reg;
        prev_src_next  = prev_src_reg;
        span_next      = span_reg;
        neg_next       = neg_reg;
        held_frac_next = held_frac_reg;
        la_next        = la_reg;
        lb_next        = lb_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        mil_next       = mil_reg;
        mir_next       = mir_reg;
        res_kind_next  = res_kind_reg;
        res_index_next = res_index_reg;
        res_frac_next  = res_frac_reg;
        res_ml_next    = res_ml_reg;
        res_mr_next    = res_mr_reg;
        u_ctrl_next    = '{start: 1'b0, op: u_ctrl_reg.op, steps: u_ctrl_reg.steps};
        u_a_next       = u_a_reg;
        u_b_next       = u_b_reg;
        u_c_next       = u_c_reg;
        rd_addr        = '0;
        fin_map        = 1'b0;
        fin_src        = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    la_next  = in_la;
                    lb_next  = in_lb;
                    ra_next  = in_ra;
                    rb_next  = in_rb;
                    mil_next = in_mil;
                    mir_next = in_mir;
                    if (in_action == mwr_pkg::ACT_MAP) begin
                        if (!map_avail) begin
                            res_kind_next  = mwr_pkg::KIND_UNAVAIL;
                            res_index_next = '0;
                            res_frac_next  = '0;
                            res_ml_next    = '0;
                            res_mr_next    = '0;
                            state_next     = S_OUT;
                        end else if (beat_sat) begin
                            // saturated beat lands on the last marker
                            beat_next  = '1;
                            rd_addr    = last_addr;
                            state_next = S_HI;
                        end else begin
                            u_ctrl_next = '{start: 1'b1, op: mwr_pkg::OP_DIV,
                                            steps: mwr_pkg::STEPS_BEAT};
                            u_a_next    = mwr_pkg::ACC_W'(spb_reg);
                            u_b_next    = {in_pos[7:0], 40'b0};
                            u_c_next    = {8'b0, in_pos[39:8]};
                            state_next  = S_BDIV;
                        end
                    end else if (in_action == mwr_pkg::ACT_MIX) begin
                        u_ctrl_next = '{start: 1'b1, op: mwr_pkg::OP_MUL,
                                        steps: mwr_pkg::STEPS_FRAC};
                        u_a_next    = {{63{diff_l[24]}}, diff_l};
                        u_b_next    = mwr_pkg::MLT_W'(held_frac_reg);
                        u_c_next    = '0;
                        state_next  = S_M1L;
                    end
                end
            end
            S_BDIV: begin
                if (u_done) begin
                    beat_next  = q48[39:0];
                    rd_addr    = last_addr;
                    state_next = S_HI;
                end
            end
            S_HI: begin
                hi_next       = (beat_reg >= rd_beat_reg);
                last_src_next = rd_src_reg;
                rd_addr       = '0;
                state_next    = S_LO;
            end
            S_LO: begin
                priority if (beat_reg <= rd_beat_reg) begin
                    fin_map = 1'b1;
                    fin_src = rd_src_reg;
                end else if (hi_reg) begin
                    fin_map = 1'b1;
                    fin_src = last_src_reg;
                end else begin
                    prev_beat_next = rd_beat_reg;
                    prev_src_next  = rd_src_reg;
                    j_next         = AW'(1);
                    rd_addr        = AW'(1);
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                priority if (beat_reg < rd_beat_reg) begin
                    if (rd_beat_reg <= prev_beat_reg) begin
                        // empty segment: hold its start
                        fin_map = 1'b1;
                        fin_src = prev_src_reg;
                    end else begin
                        span_next   = seg_span;
                        neg_next    = (rd_src_reg < prev_src_reg);
                        u_ctrl_next = '{start: 1'b1, op: mwr_pkg::OP_MUL,
                                        steps: mwr_pkg::STEPS_PROD};
                        u_a_next    = mwr_pkg::ACC_W'(seg_mag);
                        u_b_next    = mwr_pkg::MLT_W'(seg_d);
                        u_c_next    = '0;
                        state_next  = S_PMUL;
                    end
                end else if (j_reg == last_addr) begin
                    fin_map = 1'b1;
                    fin_src = last_src_reg;
                end else begin
                    prev_beat_next = rd_beat_reg;
                    prev_src_next  = rd_src_reg;
                    j_next         = j_reg + 1'b1;
                    rd_addr        = j_reg + 1'b1;
                end
            end
            S_PMUL: begin
                if (u_done) begin
                    u_ctrl_next = '{start: 1'b1, op: mwr_pkg::OP_DIV,
                                    steps: mwr_pkg::STEPS_SEG};
                    u_a_next    = mwr_pkg::ACC_W'(span_reg);
                    u_b_next    = u_res[47:0];
                    u_c_next    = u_res[87:48];
                    state_next  = S_SDIV;
                end
            end
            S_SDIV: begin
                if (u_done) begin
                    fin_map = 1'b1;
                    fin_src = neg_reg ? (prev_src_reg - q48) : (prev_src_reg + q48);
                end
            end
            S_M1L, S_M1R: begin
                if (u_done) begin
                    u_ctrl_next = '{start: 1'b1, op: mwr_pkg::OP_MUL,
                                    steps: mwr_pkg::STEPS_GAIN};
                    u_a_next    = {{46{v_mix[41]}}, v_mix};
                    u_b_next    = mwr_pkg::MLT_W'(gain_reg);
                    u_c_next    = '0;
                    state_next  = (state_reg == S_M1L) ? S_M2L : S_M2R;
                end
            end
            S_M2L: begin
                if (u_done) begin
                    res_ml_next = mwr_pkg::mix_finish(u_res[59:0], mil_reg);
                    u_ctrl_next = '{start: 1'b1, op: mwr_pkg::OP_MUL,
                                    steps: mwr_pkg::STEPS_FRAC};
                    u_a_next    = {{63{diff_r[24]}}, diff_r};
                    u_b_next    = mwr_pkg::MLT_W'(held_frac_reg);
                    u_c_next    = '0;
                    state_next  = S_M1R;
                end
            end
            S_M2R: begin
                if (u_done) begin
                    res_mr_next    = mwr_pkg::mix_finish(u_res[59:0], mir_reg);
                    res_kind_next  = mwr_pkg::KIND_MIXED;
                    res_index_next = '0;
                    res_frac_next  = '0;
                    state_next     = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // mapped position: split into index and fraction, keep the fraction
        if (fin_map) begin
            res_kind_next  = mwr_pkg::KIND_MAPPED;
            res_index_next = fin_src[47:16];
            res_frac_next  = fin_src[15:0];
            res_ml_next    = '0;
            res_mr_next    = '0;
            held_frac_next = fin_src[15:0];
            state_next     = S_OUT;
        end
    end

    // Output register: load from the pending result, drop once taken
    always_comb begin
        m_valid_next   = m_valid_reg;
        out_kind_next  = out_kind_reg;
        out_index_next = out_index_reg;
        out_frac_next  = out_frac_reg;
        out_ml_next    = out_ml_reg;
        out_mr_next    = out_mr_reg;
        if (out_load) begin
            m_valid_next   = 1'b1;
            out_kind_next  = res_kind_reg;
            out_index_next = res_index_reg;
            out_frac_next  = res_frac_reg;
            out_ml_next    = res_ml_reg;
            out_mr_next    = res_mr_reg;
        end else if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            held_frac_reg <= '0;
            u_ctrl_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            held_frac_reg <= held_frac_next;
            u_ctrl_reg    <= u_ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        beat_reg      <= beat_next;
        j_reg         <= j_next;
        hi_reg        <= hi_next;
        last_src_reg  <= last_src_next;
        prev_beat_reg <= prev_beat_next;
        prev_src_reg  <= prev_src_next;
        span_reg      <= span_next;
        neg_reg       <= neg_next;
        la_reg        <= la_next;
        lb_reg        <= lb_next;
        ra_reg        <= ra_next;
        rb_reg        <= rb_next;
        mil_reg       <= mil_next;
        mir_reg       <= mir_next;
        res_kind_reg  <= res_kind_next;
        res_index_reg <= res_index_next;
        res_frac_reg  <= res_frac_next;
        res_ml_reg    <= res_ml_next;
        res_mr_reg    <= res_mr_next;
        u_a_reg       <= u_a_next;
        u_b_reg       <= u_b_next;
        u_c_reg       <= u_c_next;
        out_kind_reg  <= out_kind_next;
        out_index_reg <= out_index_next;
        out_frac_reg  <= out_frac_next;
        out_ml_reg    <= out_ml_next;
        out_mr_reg    <= out_mr_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_mr_reg, out_ml_reg, out_frac_reg, out_index_reg};
    assign m_tuser  = out_kind_reg;

`ifndef SYNTHESIS
    // the shift unit only finishes while the sequencer waits on it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        u_done |-> (state_reg == S_BDIV || state_reg == S_PMUL || state_reg == S_SDIV
                    || state_reg == S_M1L || state_reg == S_M1R
                    || state_reg == S_M2L || state_reg == S_M2R))
        else $error("shift unit done outside a wait state");

    // an accepted map word always leaves the sequencer busy in the following cycle
    a_map_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && in_action == mwr_pkg::ACT_MAP) |=> !s_tready)
        else $error("map word accepted without leaving idle");

    // a mapped result carries the fraction that later mix words use
    a_held_frac: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && res_kind_reg == mwr_pkg::KIND_MAPPED)
            |=> (m_tdata[47:32] == held_frac_reg))
        else $error("held fraction differs from mapped fraction");
`endif

endmodule
